// ===== rtl/core/kwma_pkg.sv =====
// package for the keyed weighted-mean aggregator
// table sizes, field widths, opcodes and the divider request type
`default_nettype none
package kwma_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int ROWS_W      = $clog2(TABLE_DEPTH + 1);

  localparam int KEY_W   = 32;
  localparam int CNT_W   = 16;
  localparam int DEP_W   = 16;
  localparam int CSUM_W  = 40;
  localparam int WSUM_W  = 56;
  localparam int PROD_W  = CNT_W + 1 + DEP_W;
  localparam int MEAN_W  = 32;
  localparam int FRAC_W  = 16;
  localparam int DEN_W   = CSUM_W + 4;
  localparam int NUM_W   = WSUM_W + FRAC_W;
  localparam int QUO_W   = MEAN_W + 1;
  localparam int STEP_W  = $clog2(NUM_W + 1);

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic              start;
    logic              neg;
    logic [WSUM_W-1:0] mag;
    logic [CSUM_W-1:0] csum;
  } div_req_t;

endpackage
`default_nettype wire

// ===== rtl/core/kwma_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module kwma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wa,
  input  wire logic [WIDTH-1:0]         wd,
  input  wire logic [$clog2(DEPTH)-1:0] ra,
  output logic      [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

endmodule
`default_nettype wire

// ===== rtl/core/kwma_div.sv =====
// restoring divider: trunc(+-mag * 2^16 / (10 * csum)), saturated to signed 32 bits
// one quotient bit per cycle; uses kwma_pkg
`default_nettype none
module kwma_div
  import kwma_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire div_req_t          req,
  output logic                   done,
  output logic      [MEAN_W-1:0] mean
);

  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [QUO_W-1:0]  quo_r, quo_nxt;
  logic              ovf_r, ovf_nxt;
  logic              neg_r, neg_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              ge;
  logic              big;

  assign trial = {rem_r, num_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    ovf_nxt  = ovf_r;
    neg_nxt  = neg_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      num_nxt  = {req.mag, {FRAC_W{1'b0}}};
      // 10 * csum as two shifted copies
      den_nxt  = {1'b0, req.csum, 3'b000} + {3'b000, req.csum, 1'b0};
      rem_nxt  = '0;
      quo_nxt  = '0;
      ovf_nxt  = 1'b0;
      neg_nxt  = req.neg;
      step_nxt = STEP_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      num_nxt  = {num_r[NUM_W-2:0], 1'b0};
      ovf_nxt  = ovf_r | quo_r[QUO_W-1];
      quo_nxt  = {quo_r[QUO_W-2:0], ge};
      step_nxt = step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    ovf_r  <= ovf_nxt;
    neg_r  <= neg_nxt;
    step_r <= step_nxt;
  end

  assign done = done_r;
  assign big  = ovf_r | quo_r[QUO_W-1] | quo_r[MEAN_W-1];

  always_comb begin
    if (neg_r) begin
      mean = big ? {1'b1, {(MEAN_W-1){1'b0}}} : (~quo_r[MEAN_W-1:0] + MEAN_W'(1));
    end else begin
      mean = big ? {1'b0, {(MEAN_W-1){1'b1}}} : quo_r[MEAN_W-1:0];
    end
  end

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a running division");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !req.start)
    else $error("divider restarted while busy");
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rem_r < den_r)
    else $error("divider remainder out of range");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/keyed_weighted_mean_aggregator_top.sv =====
// keyed weighted-mean aggregator, top level: sequencer, key and sum tables
// uses kwma_pkg, kwma_ram and kwma_div
//
// input channel in_*: op 0 adds a record (count, grid_key, depth), op 1 flushes.
// an add scans the rows in insertion order, one row per cycle, and then updates
// the matching row or appends one; a full table drops the record and sets a
// sticky flag.
// a flush gives one result per row on out_*, in insertion order, each with the
// key and the mean sum(count*depth)/sum(count)/10 as signed q16; the last
// result carries out_last. an empty table gives one result with row_valid low.
// the bit-serial divider (72 steps) sets most of the time per row.
// in_stall stays high from an accepted transfer until its work is done,
// including every flush result being taken. one result register feeds out_*;
// while out_stall is high the result holds and the sequencer waits.
// reset (synchronous, rst_n low) empties the table and clears the drop flag;
// no clearing pass is needed since only written rows are read.
`default_nettype none
module keyed_weighted_mean_aggregator_top
  import kwma_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     in_op,
  input  wire logic        [CNT_W-1:0]  in_count,
  input  wire logic signed [KEY_W-1:0]  in_grid_key,
  input  wire logic signed [DEP_W-1:0]  in_depth,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed      [KEY_W-1:0]  out_key,
  output logic signed      [MEAN_W-1:0] out_mean_q16,
  output logic                          out_mean_valid,
  output logic                          out_row_valid,
  output logic                          out_dropped,
  output logic                          out_last
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_UPD    = 7'b0000100,
    S_FL_RD  = 7'b0001000,
    S_FL_LAT = 7'b0010000,
    S_FL_DIV = 7'b0100000,
    S_FL_OUT = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [ROWS_W-1:0]   rows_r, rows_nxt;
  logic                drop_r, drop_nxt;
  logic [ROWS_W-1:0]   scan_r, scan_nxt;
  logic                chk_v_r, chk_v_nxt;
  logic [IDX_W-1:0]    chk_idx_r, chk_idx_nxt;
  logic [ROWS_W-1:0]   fl_r, fl_nxt;
  logic                ov_r, ov_nxt;

  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [IDX_W-1:0]    upd_idx_r, upd_idx_nxt;
  logic [CSUM_W-1:0]   upd_cs_r, upd_cs_nxt;
  logic [WSUM_W-1:0]   upd_ws_r, upd_ws_nxt;

  logic [KEY_W-1:0]    o_key_r, o_key_nxt;
  logic [MEAN_W-1:0]   o_mean_r, o_mean_nxt;
  logic                o_mv_r, o_mv_nxt;
  logic                o_rv_r, o_rv_nxt;
  logic                o_drop_r, o_drop_nxt;
  logic                o_last_r, o_last_nxt;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_wa;
  logic [IDX_W-1:0]    ram_ra;
  logic [KEY_W-1:0]    key_wd, key_rd;
  logic [CSUM_W-1:0]   cs_wd, cs_rd;
  logic [WSUM_W-1:0]   ws_wd, ws_rd;

  div_req_t            div_req;
  logic                div_done;
  logic [MEAN_W-1:0]   div_mean;

  logic [CSUM_W:0]     cs_sum;
  logic [WSUM_W:0]     ws_sum;
  logic                last_row;
  logic [PROD_W-1:0]   prod_in;

  kwma_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
    .clk(clk), .we(ram_we), .wa(ram_wa), .wd(key_wd), .ra(ram_ra), .rd(key_rd)
  );
  kwma_ram #(.WIDTH(CSUM_W), .DEPTH(TABLE_DEPTH)) u_cs_ram (
    .clk(clk), .we(ram_we), .wa(ram_wa), .wd(cs_wd), .ra(ram_ra), .rd(cs_rd)
  );
  kwma_ram #(.WIDTH(WSUM_W), .DEPTH(TABLE_DEPTH)) u_ws_ram (
    .clk(clk), .we(ram_we), .wa(ram_wa), .wd(ws_wd), .ra(ram_ra), .rd(ws_rd)
  );

  kwma_div u_div (
    .clk(clk), .rst_n(rst_n), .req(div_req), .done(div_done), .mean(div_mean)
  );

  // both operands widened to the full product width
  assign prod_in  = $signed({{DEP_W{1'b0}}, 1'b0, in_count})
                  * $signed({{(CNT_W+1){in_depth[DEP_W-1]}}, in_depth});
  assign cs_sum   = {1'b0, upd_cs_r} + (CSUM_W+1)'(cnt_r);
  assign ws_sum   = {upd_ws_r[WSUM_W-1], upd_ws_r}
                  + {{(WSUM_W+1-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign last_row = (fl_r + ROWS_W'(1)) == rows_r;
  assign ram_ra   = (state_r == S_SCAN) ? scan_r[IDX_W-1:0] : fl_r[IDX_W-1:0];

  always_comb begin
    state_nxt   = state_r;
    rows_nxt    = rows_r;
    drop_nxt    = drop_r;
    scan_nxt    = scan_r;
    chk_v_nxt   = chk_v_r;
    chk_idx_nxt = chk_idx_r;
    fl_nxt      = fl_r;
    ov_nxt      = ov_r;
    key_nxt     = key_r;
    cnt_nxt     = cnt_r;
    prod_nxt    = prod_r;
    upd_idx_nxt = upd_idx_r;
    upd_cs_nxt  = upd_cs_r;
    upd_ws_nxt  = upd_ws_r;
    o_key_nxt   = o_key_r;
    o_mean_nxt  = o_mean_r;
    o_mv_nxt    = o_mv_r;
    o_rv_nxt    = o_rv_r;
    o_drop_nxt  = o_drop_r;
    o_last_nxt  = o_last_r;
    ram_we      = 1'b0;
    ram_wa      = rows_r[IDX_W-1:0];
    key_wd      = key_r;
    cs_wd       = CSUM_W'(cnt_r);
    ws_wd       = {{(WSUM_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    div_req     = '0;
    div_req.neg = upd_ws_r[WSUM_W-1];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_ADD) begin
            key_nxt   = in_grid_key;
            cnt_nxt   = in_count;
            prod_nxt  = prod_in;
            scan_nxt  = '0;
            chk_v_nxt = 1'b0;
            state_nxt = S_SCAN;
          end else begin
            o_drop_nxt = drop_r;
            drop_nxt   = 1'b0;
            fl_nxt     = '0;
            if (rows_r == '0) begin
              o_key_nxt  = '0;
              o_mean_nxt = '0;
              o_mv_nxt   = 1'b0;
              o_rv_nxt   = 1'b0;
              o_last_nxt = 1'b1;
              ov_nxt     = 1'b1;
              state_nxt  = S_FL_OUT;
            end else begin
              state_nxt = S_FL_RD;
            end
          end
        end
      end
      S_SCAN: begin
        // reads are issued one row ahead of the key compare
        if (chk_v_r && key_rd == key_r) begin
          upd_idx_nxt = chk_idx_r;
          upd_cs_nxt  = cs_rd;
          upd_ws_nxt  = ws_rd;
          chk_v_nxt   = 1'b0;
          state_nxt   = S_UPD;
        end else if (scan_r < rows_r) begin
          chk_v_nxt   = 1'b1;
          chk_idx_nxt = scan_r[IDX_W-1:0];
          scan_nxt    = scan_r + ROWS_W'(1);
        end else if (chk_v_r) begin
          chk_v_nxt = 1'b0;
        end else begin
          if (rows_r < ROWS_W'(TABLE_DEPTH)) begin
            ram_we   = 1'b1;
            rows_nxt = rows_r + ROWS_W'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      S_UPD: begin
        ram_we = 1'b1;
        ram_wa = upd_idx_r;
        cs_wd  = cs_sum[CSUM_W] ? {CSUM_W{1'b1}} : cs_sum[CSUM_W-1:0];
        // saturate when the two top bits disagree
        if (ws_sum[WSUM_W] != ws_sum[WSUM_W-1]) begin
          ws_wd = {ws_sum[WSUM_W], {(WSUM_W-1){~ws_sum[WSUM_W]}}};
        end else begin
          ws_wd = ws_sum[WSUM_W-1:0];
        end
        state_nxt = S_IDLE;
      end
      S_FL_RD: begin
        state_nxt = S_FL_LAT;
      end
      S_FL_LAT: begin
        o_key_nxt  = key_rd;
        o_rv_nxt   = 1'b1;
        o_last_nxt = last_row;
        upd_ws_nxt = ws_rd;
        if (cs_rd == '0) begin
          o_mean_nxt = '0;
          o_mv_nxt   = 1'b0;
          ov_nxt     = 1'b1;
          state_nxt  = S_FL_OUT;
        end else begin
          div_req.start = 1'b1;
          div_req.neg   = ws_rd[WSUM_W-1];
          div_req.mag   = ws_rd[WSUM_W-1] ? (~ws_rd + WSUM_W'(1)) : ws_rd;
          div_req.csum  = cs_rd;
          state_nxt     = S_FL_DIV;
        end
      end
      S_FL_DIV: begin
        if (div_done) begin
          o_mean_nxt = div_mean;
          o_mv_nxt   = 1'b1;
          ov_nxt     = 1'b1;
          state_nxt  = S_FL_OUT;
        end
      end
      S_FL_OUT: begin
        if (!out_stall) begin
          ov_nxt = 1'b0;
          if (o_last_r) begin
            rows_nxt  = '0;
            state_nxt = S_IDLE;
          end else begin
            fl_nxt    = fl_r + ROWS_W'(1);
            state_nxt = S_FL_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rows_r  <= '0;
      drop_r  <= 1'b0;
      chk_v_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rows_r  <= rows_nxt;
      drop_r  <= drop_nxt;
      chk_v_r <= chk_v_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r    <= scan_nxt;
    chk_idx_r <= chk_idx_nxt;
    fl_r      <= fl_nxt;
    key_r     <= key_nxt;
    cnt_r     <= cnt_nxt;
    prod_r    <= prod_nxt;
    upd_idx_r <= upd_idx_nxt;
    upd_cs_r  <= upd_cs_nxt;
    upd_ws_r  <= upd_ws_nxt;
    o_key_r   <= o_key_nxt;
    o_mean_r  <= o_mean_nxt;
    o_mv_r    <= o_mv_nxt;
    o_rv_r    <= o_rv_nxt;
    o_drop_r  <= o_drop_nxt;
    o_last_r  <= o_last_nxt;
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = ov_r;
  assign out_key        = o_key_r;
  assign out_mean_q16   = o_mean_r;
  assign out_mean_valid = o_mv_r;
  assign out_row_valid  = o_rv_r;
  assign out_dropped    = o_drop_r;
  assign out_last       = o_last_r;

`ifndef SYNTHESIS
  a_rows_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rows_r <= ROWS_W'(TABLE_DEPTH))
    else $error("row count beyond table depth");
  a_out_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> state_r == S_FL_OUT)
    else $error("result shown outside the flush output state");
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_FL_DIV)
    else $error("divider finished outside the divide state");
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_stall && o_last_r) |=> (rows_r == '0 && !drop_r))
    else $error("table not cleared after the last flush transfer");
`endif

endmodule
`default_nettype wire
